// ===== src/bcrf_pkg.sv =====
// Package for the border connected region fill unit: types and constants.
`timescale 1ns / 1ps

package bcrf_pkg;

  localparam int MaxRowsDef = 64;
  localparam int MaxColsDef = 64;

  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 7;
  localparam logic [CfgDataW-1:0] SizeReset = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_ROWS = 2'd0,
    REG_NUM_COLS = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [5:0] row_index;
    logic [5:0] col_index;
    logic       cell_open;
  } in_item_t;

  typedef struct packed {
    logic read_open;
    logic range_error;
  } out_item_t;

  // One grid entry: the walk mark and the cell value.
  typedef struct packed {
    logic mark;
    logic open;
  } cell_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED_COLS,
    ST_SEED_ROWS,
    ST_POP,
    ST_NBR,
    ST_SWEEP,
    ST_FINISH
  } fsm_e;

endpackage

// ===== src/border_connected_region_fill_unit.sv =====
// Top level of the border connected region fill unit (binary hole fill, 4-connected).
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries commands:
//   write cell, run fill, read cell. Every transfer gives exactly one result
//   on the output channel (out_valid_o / out_stall_i / out_data_o).
//   For write and read the result is registered and shows in the cycle after
//   the transfer; back-to-back items are taken at one per cycle while the
//   receiver does not stall. A run holds in_stall_o high while it works on
//   the cell memory: it seeds the border cells, then takes one queue pop plus
//   four neighbor probes through the single read port of the cell memory per
//   border-connected open cell, sweeps every cell and finishes.
//   Reset starts a clearing pass over all 2^(RW+CW) entries (4096 at 64x64)
//   that zeroes the cell memory; input is stalled during it, configuration
//   writes are taken. Size registers reset to 64.
//   When the receiver stalls, the result holds and a new input transfer is
//   taken only in the cycle the pending result leaves.
//   cfg_we_i / cfg_idx_i / cfg_data_i write num_rows (0) and num_cols (1).

module border_connected_region_fill_unit
  import bcrf_pkg::*;
#(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int QPW   = AW + 1;
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLS + 1);

  // Configuration
  logic [CfgDataW-1:0] num_rows_q, num_cols_q;
  logic [RNW-1:0]      eff_rows;
  logic [CNW-1:0]      eff_cols;
  logic [RW-1:0]       last_row;
  logic [CW-1:0]       last_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= SizeReset;
      num_cols_q <= SizeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_ROWS: num_rows_q <= cfg_data_i;
        REG_NUM_COLS: num_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the maximum
  always_comb begin
    if (num_rows_q == '0) begin
      eff_rows = RNW'(1);
    end else if (int'(num_rows_q) > MAX_ROWS) begin
      eff_rows = RNW'(MAX_ROWS);
    end else begin
      eff_rows = RNW'(num_rows_q);
    end
    if (num_cols_q == '0) begin
      eff_cols = CNW'(1);
    end else if (int'(num_cols_q) > MAX_COLS) begin
      eff_cols = CNW'(MAX_COLS);
    end else begin
      eff_cols = CNW'(num_cols_q);
    end
  end

  assign last_row = RW'(eff_rows - RNW'(1));
  assign last_col = CW'(eff_cols - CNW'(1));

  // Control state
  fsm_e            state_q, state_d;
  logic [AW-1:0]   clear_cnt_q, clear_cnt_d;
  logic [RW-1:0]   scan_r_q, scan_r_d;
  logic [CW-1:0]   scan_c_q, scan_c_d;
  logic            side_q, side_d;
  logic [1:0]      nbr_sel_q, nbr_sel_d;
  logic [QPW-1:0]  head_q, head_d, tail_q, tail_d;
  logic            cand_vld_q, fwd_vld_q, swp_vld_q;
  logic [AW-1:0]   cand_addr_q, fwd_addr_q, swp_addr_q;
  logic            out_valid_q, out_valid_d;
  logic            out_rd_q, out_rd_d, out_err_q, out_err_d;

  // Memories
  cell_t           cell_mem [DEPTH];
  cell_t           cell_rd_q;
  logic [AW-1:0]   queue_mem [DEPTH];
  logic [AW-1:0]   q_rd_q;

  logic            cell_we, cell_re;
  logic [AW-1:0]   cell_waddr, cell_raddr;
  cell_t           cell_wdata;

  // Input decode
  logic            in_accept, in_inside, is_run, is_read, is_write;
  logic [AW-1:0]   in_addr;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_run     = (in_data_i.cmd == CMD_RUN);
  assign is_read    = (in_data_i.cmd == CMD_READ);
  assign is_write   = (in_data_i.cmd == CMD_WRITE);
  assign in_inside  = (int'(in_data_i.row_index) < int'(eff_rows)) &&
                      (int'(in_data_i.col_index) < int'(eff_cols));
  assign in_addr    = {RW'(in_data_i.row_index), CW'(in_data_i.col_index)};

  // Probe check: the entry read last cycle; the mark written at the edge
  // of that read is forwarded since the read saw the old value.
  logic cand_marked, push, pop;
  assign cand_marked = cell_rd_q.mark || (fwd_vld_q && (fwd_addr_q == cand_addr_q));
  assign push        = cand_vld_q && cell_rd_q.open && !cand_marked;

  // Neighbor coordinates of the popped cell
  logic [RW-1:0] pop_r;
  logic [CW-1:0] pop_c;
  assign pop_r = q_rd_q[AW-1:CW];
  assign pop_c = q_rd_q[CW-1:0];

  logic          gen_vld;
  logic [AW-1:0] gen_addr;

  always_comb begin
    state_d     = state_q;
    clear_cnt_d = clear_cnt_q;
    scan_r_d    = scan_r_q;
    scan_c_d    = scan_c_q;
    side_d      = side_q;
    nbr_sel_d   = nbr_sel_q;
    head_d      = head_q;
    tail_d      = push ? tail_q + QPW'(1) : tail_q;
    gen_vld     = 1'b0;
    gen_addr    = {scan_r_q, scan_c_q};
    pop         = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_rd_d    = out_rd_q;
    out_err_d   = out_err_q;

    unique case (state_q)
      ST_CLEAR: begin
        clear_cnt_d = clear_cnt_q + AW'(1);
        if (clear_cnt_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          if (is_run) begin
            state_d  = ST_SEED_COLS;
            scan_c_d = '0;
            side_d   = 1'b0;
            head_d   = '0;
            tail_d   = '0;
          end else begin
            out_valid_d = 1'b1;
            out_rd_d    = is_read && in_inside;
            out_err_d   = (is_read || is_write) && !in_inside;
          end
        end
      end
      ST_SEED_COLS: begin
        // top and bottom row, one cell a cycle
        gen_vld  = 1'b1;
        gen_addr = {(side_q ? last_row : RW'(0)), scan_c_q};
        side_d   = !side_q;
        if (side_q) begin
          if (scan_c_q == last_col) begin
            if (int'(eff_rows) > 2) begin
              state_d  = ST_SEED_ROWS;
              scan_r_d = RW'(1);
            end else begin
              state_d = ST_POP;
            end
          end else begin
            scan_c_d = scan_c_q + CW'(1);
          end
        end
      end
      ST_SEED_ROWS: begin
        // left and right column without the corners
        gen_vld  = 1'b1;
        gen_addr = {scan_r_q, (side_q ? last_col : CW'(0))};
        side_d   = !side_q;
        if (side_q) begin
          if (int'(scan_r_q) + 2 == int'(eff_rows)) begin
            state_d = ST_POP;
          end else begin
            scan_r_d = scan_r_q + RW'(1);
          end
        end
      end
      ST_POP: begin
        if (head_q != tail_q) begin
          pop       = 1'b1;
          head_d    = head_q + QPW'(1);
          nbr_sel_d = '0;
          state_d   = ST_NBR;
        end else if (!cand_vld_q) begin
          // queue empty and no probe left that could push
          scan_r_d = '0;
          scan_c_d = '0;
          state_d  = ST_SWEEP;
        end
      end
      ST_NBR: begin
        unique case (nbr_sel_q)
          2'd0: begin
            gen_vld  = (pop_r != '0);
            gen_addr = {pop_r - RW'(1), pop_c};
          end
          2'd1: begin
            gen_vld  = (int'(pop_r) + 1 < int'(eff_rows));
            gen_addr = {pop_r + RW'(1), pop_c};
          end
          2'd2: begin
            gen_vld  = (pop_c != '0);
            gen_addr = {pop_r, pop_c - CW'(1)};
          end
          default: begin
            gen_vld  = (int'(pop_c) + 1 < int'(eff_cols));
            gen_addr = {pop_r, pop_c + CW'(1)};
          end
        endcase
        nbr_sel_d = nbr_sel_q + 2'd1;
        if (nbr_sel_q == 2'd3) begin
          state_d = ST_POP;
        end
      end
      ST_SWEEP: begin
        if (scan_c_q == last_col) begin
          scan_c_d = '0;
          if (scan_r_q == last_row) begin
            state_d = ST_FINISH;
          end else begin
            scan_r_d = scan_r_q + RW'(1);
          end
        end else begin
          scan_c_d = scan_c_q + CW'(1);
        end
      end
      ST_FINISH: begin
        // last write-back lands at this edge
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        out_rd_d    = 1'b0;
        out_err_d   = 1'b0;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell memory port selection
  always_comb begin
    cell_re    = 1'b0;
    cell_raddr = gen_addr;
    if (state_q == ST_IDLE) begin
      cell_re    = in_accept && is_read && in_inside;
      cell_raddr = in_addr;
    end else if (state_q == ST_SWEEP) begin
      cell_re    = 1'b1;
      cell_raddr = {scan_r_q, scan_c_q};
    end else begin
      cell_re = gen_vld;
    end
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = in_addr;
    cell_wdata = '{mark: 1'b0, open: in_data_i.cell_open};
    priority if (state_q == ST_CLEAR) begin
      cell_we    = 1'b1;
      cell_waddr = clear_cnt_q;
      cell_wdata = '{mark: 1'b0, open: 1'b0};
    end else if (swp_vld_q) begin
      // close unmarked open cells, drop the mark
      cell_we    = 1'b1;
      cell_waddr = swp_addr_q;
      cell_wdata = '{mark: 1'b0, open: cell_rd_q.open & cell_rd_q.mark};
    end else if (push) begin
      cell_we    = 1'b1;
      cell_waddr = cand_addr_q;
      cell_wdata = '{mark: 1'b1, open: 1'b1};
    end else begin
      cell_we = (state_q == ST_IDLE) && in_accept && is_write && in_inside;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_q <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_mem[tail_q[AW-1:0]] <= cand_addr_q;
    end
    if (pop) begin
      q_rd_q <= queue_mem[head_q[AW-1:0]];
    end
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clear_cnt_q <= '0;
      scan_r_q    <= '0;
      scan_c_q    <= '0;
      side_q      <= 1'b0;
      nbr_sel_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      cand_vld_q  <= 1'b0;
      fwd_vld_q   <= 1'b0;
      swp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_rd_q    <= 1'b0;
      out_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clear_cnt_q <= clear_cnt_d;
      scan_r_q    <= scan_r_d;
      scan_c_q    <= scan_c_d;
      side_q      <= side_d;
      nbr_sel_q   <= nbr_sel_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cand_vld_q  <= gen_vld;
      fwd_vld_q   <= push;
      swp_vld_q   <= (state_q == ST_SWEEP);
      out_valid_q <= out_valid_d;
      out_rd_q    <= out_rd_d;
      out_err_q   <= out_err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_addr_q <= gen_addr;
    fwd_addr_q  <= cand_addr_q;
    swp_addr_q  <= {scan_r_q, scan_c_q};
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.read_open  = out_rd_q & cell_rd_q.open;
  assign out_data_o.range_error = out_err_q;

  // Checks
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  a_push_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (state_q == ST_SEED_COLS || state_q == ST_SEED_ROWS ||
              state_q == ST_POP || state_q == ST_NBR))
    else $error("mark write outside the walk");

  a_no_wb_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(swp_vld_q && push))
    else $error("sweep write-back collides with mark write");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(in_accept) || $past(state_q == ST_FINISH)))
    else $error("result without a transfer or finished run");

  a_sweep_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> (head_q == tail_q && !cand_vld_q))
    else $error("sweep started with walk pending");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the border connected region fill unit.
`timescale 1ns / 1ps

module tb_top
  import bcrf_pkg::*;
;

  // Generous stop: RunLimitNs sits well beyond what a good run needs. A full
  // 64x64 fill and the reset clear are the long stretches, and only a few
  // phases use the largest sizes.
  localparam int unsigned RunLimitNs = 40_000_000;
  localparam int RandomItems = 1000;
  localparam int CellCount = MaxRowsDef * MaxColsDef;
  // Largest edge of the patch that each random phase paints, then reads back.
  localparam int PatchMax = 8;
  localparam int PlanLen = 32;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;
  localparam logic [CfgIdxW-1:0] NoReg = '0;
  localparam in_item_t NoCell = '0;

  localparam out_item_t ResQuiet = '{read_open: 1'b0, range_error: 1'b0};
  localparam out_item_t ResOpen  = '{read_open: 1'b1, range_error: 1'b0};
  localparam out_item_t ResRange = '{read_open: 1'b0, range_error: 1'b1};

  // A directed row is either a register write or a cell command. A cell row
  // carries a fixed result where it is obvious, and otherwise asks the
  // predictor.
  typedef enum logic {ROW_CELL, ROW_REG} row_kind_e;
  typedef enum logic [1:0] {WANT_MODEL, WANT_QUIET, WANT_OPEN, WANT_RANGE} want_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_val;
    in_item_t            item;
    want_e               want;
  } plan_row_t;

  localparam plan_row_t Plan [PlanLen] = '{
    // After reset the 64x64 grid is all closed.
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd0,  6'd0,  1'b0}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd63, 6'd63, 1'b0}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd63, 6'd63, 1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd63, 6'd63, 1'b0}, WANT_OPEN},
    // Lone hole at (2,2), and a chain hanging from the top edge.
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd2,  6'd2,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd0,  6'd5,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd1,  6'd5,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd2,  6'd5,  1'b1}, WANT_QUIET},
    // Unused command: no effect, quiet result.
    '{ROW_CELL, NoReg, 7'd0, {CmdUnused, 6'd63, 6'd63, 1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_RUN,   6'd0,  6'd0,  1'b0}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd2,  6'd2,  1'b0}, WANT_MODEL},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd2,  6'd5,  1'b0}, WANT_MODEL},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd63, 6'd63, 1'b0}, WANT_MODEL},
    // Zero rows acts as one; 127 columns is clamped to 64.
    '{ROW_REG, REG_NUM_ROWS, 7'd0,   NoCell, WANT_MODEL},
    '{ROW_REG, REG_NUM_COLS, 7'd127, NoCell, WANT_MODEL},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd1,  6'd0,  1'b0}, WANT_RANGE},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd0,  6'd62, 1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_RUN,   6'd0,  6'd0,  1'b0}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd0,  6'd62, 1'b0}, WANT_MODEL},
    // Writes to indexes past the last register are dropped.
    '{ROW_REG, RegSpareLo,   7'd5, NoCell, WANT_MODEL},
    '{ROW_REG, RegSpareHi,   7'd0, NoCell, WANT_MODEL},
    '{ROW_REG, REG_NUM_ROWS, 7'd5, NoCell, WANT_MODEL},
    '{ROW_REG, REG_NUM_COLS, 7'd5, NoCell, WANT_MODEL},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd5,  6'd0,  1'b1}, WANT_RANGE},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd0,  6'd5,  1'b0}, WANT_RANGE},
    // (1,1)-(1,2) reach the edge through (0,1); (3,3) is enclosed.
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd1,  6'd1,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd1,  6'd2,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd0,  6'd1,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_WRITE, 6'd3,  6'd3,  1'b1}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_RUN,   6'd0,  6'd0,  1'b0}, WANT_QUIET},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd1,  6'd2,  1'b0}, WANT_MODEL},
    '{ROW_CELL, NoReg, 7'd0, {CMD_READ,  6'd3,  6'd3,  1'b0}, WANT_MODEL}
  };

  // DUT inputs start at known values.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  in_item_t            in_data_i = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_item_t           out_data_o;

  // Shadow copy of the block: grid contents, size registers and walk scratch.
  bit                  grid_open [CellCount];
  bit                  reach_mark [CellCount];
  int                  walk_q [$];
  logic [CfgDataW-1:0] rows_cfg = SizeReset;
  logic [CfgDataW-1:0] cols_cfg = SizeReset;

  out_item_t awaited_replies [$];
  int        mismatch_count = 0;
  int        useful_items = 0;
  // Set over a stretch of the random part: no gaps on either side.
  bit        steady = 1'b0;

  border_connected_region_fill_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Size in use: 0 reads as 1, anything past the maximum is clamped.
  function automatic int grid_extent(logic [CfgDataW-1:0] raw, int limit);
    if (raw == 0) return 1;
    if (int'(raw) > limit) return limit;
    return int'(raw);
  endfunction

  // Enqueue an open, unmarked cell for the border walk.
  function automatic void reach(int r, int c);
    int idx;
    idx = r * MaxColsDef + c;
    if (grid_open[idx] && !reach_mark[idx]) begin
      reach_mark[idx] = 1'b1;
      walk_q.push_back(idx);
    end
  endfunction

  // Mark everything open that connects to the edge, then close the rest.
  // Cells outside the size in use are left alone.
  function automatic void fill_holes();
    int rows, cols, idx, r, c;
    rows = grid_extent(rows_cfg, MaxRowsDef);
    cols = grid_extent(cols_cfg, MaxColsDef);
    for (c = 0; c < cols; c++) begin
      reach(0, c);
      reach(rows - 1, c);
    end
    for (r = 1; r + 1 < rows; r++) begin
      reach(r, 0);
      reach(r, cols - 1);
    end
    while (walk_q.size() != 0) begin
      idx = walk_q.pop_front();
      r = idx / MaxColsDef;
      c = idx % MaxColsDef;
      if (r > 0) reach(r - 1, c);
      if (r + 1 < rows) reach(r + 1, c);
      if (c > 0) reach(r, c - 1);
      if (c + 1 < cols) reach(r, c + 1);
    end
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        idx = r * MaxColsDef + c;
        if (!reach_mark[idx]) grid_open[idx] = 1'b0;
        reach_mark[idx] = 1'b0;
      end
    end
  endfunction

  // Result of one command; updates the shadow grid as the block would.
  function automatic out_item_t predict_reply(in_item_t it);
    out_item_t reply;
    int        idx;
    bit        on_grid;
    reply = '0;
    on_grid = (int'(it.row_index) < grid_extent(rows_cfg, MaxRowsDef)) &&
              (int'(it.col_index) < grid_extent(cols_cfg, MaxColsDef));
    idx = int'(it.row_index) * MaxColsDef + int'(it.col_index);
    case (it.cmd)
      CMD_WRITE: begin
        if (!on_grid) reply.range_error = 1'b1;
        else grid_open[idx] = it.cell_open;
      end
      CMD_READ: begin
        if (!on_grid) reply.range_error = 1'b1;
        else reply.read_open = grid_open[idx];
      end
      CMD_RUN: begin
        fill_holes();
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, int r, int c, logic v);
    in_item_t it;
    it.cmd = cmd;
    it.row_index = 6'(r);
    it.col_index = 6'(c);
    it.cell_open = v;
    return it;
  endfunction

  // One input transfer, with a random gap ahead of it. Valid stays high
  // after the transfer; the next call or the caller decides what follows.
  task automatic issue(in_item_t it, want_e want);
    out_item_t model;
    steady = (useful_items >= 300) && (useful_items < 650);
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    model = predict_reply(it);
    case (want)
      WANT_QUIET: awaited_replies.push_back(ResQuiet);
      WANT_OPEN:  awaited_replies.push_back(ResOpen);
      WANT_RANGE: awaited_replies.push_back(ResRange);
      default:    awaited_replies.push_back(model);
    endcase
    if (it.cmd != CmdUnused && !model.range_error) useful_items++;
  endtask

  // Register write, only once the block has drained and stopped stalling.
  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0 || in_stall_o) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_NUM_ROWS) rows_cfg = val;
    else if (idx == REG_NUM_COLS) cols_cfg = val;
  endtask

  // Receiver stalls at random, about 7 in 100 of the time, except in the steady stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 7);
  end

  // Check every result transfer against the oldest expectation.
  always @(posedge clk_i) begin : check_replies
    out_item_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got read_open %0b range_error %0b",
                 $time, out_data_o.read_open, out_data_o.range_error);
        mismatch_count++;
      end else begin
        head = awaited_replies.pop_front();
        if (out_data_o.read_open !== head.read_open) begin
          $display("%0t: read_open expected %0b got %0b",
                   $time, head.read_open, out_data_o.read_open);
          mismatch_count++;
        end
        if (out_data_o.range_error !== head.range_error) begin
          $display("%0t: range_error expected %0b got %0b",
                   $time, head.range_error, out_data_o.range_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #RunLimitNs;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int                  i, r, c, phase, rows_used, cols_used, patch_r, patch_c, density;
    logic [CfgDataW-1:0] rows_raw, cols_raw;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: reset contents, edges of the index range, every command,
    // size clamping, out-of-range access and spare register indexes.
    for (i = 0; i < PlanLen; i++) begin
      if (Plan[i].kind == ROW_REG) set_reg(Plan[i].reg_idx, Plan[i].reg_val);
      else issue(Plan[i].item, Plan[i].want);
    end

    // Random part, in phases. Each phase picks a size, paints a patch from
    // the top-left corner with a random open density, fills, reads the patch
    // back, then throws in a few arbitrary commands anywhere in the index space.
    useful_items = 0;
    phase = 0;
    while (useful_items < RandomItems) begin
      case (phase % 8)
        1: begin
          rows_raw = 7'd64;
          cols_raw = 7'd100;
        end
        3: begin
          rows_raw = 7'd0;
          cols_raw = 7'($urandom_range(1, 12));
        end
        5: begin
          rows_raw = 7'd127;
          cols_raw = 7'd1;
        end
        6: begin
          rows_raw = 7'd2;
          cols_raw = 7'd64;
        end
        7: begin
          rows_raw = 7'($urandom_range(1, 12));
          cols_raw = 7'd0;
        end
        default: begin
          rows_raw = 7'($urandom_range(1, 12));
          cols_raw = 7'($urandom_range(1, 12));
        end
      endcase
      set_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, 7'($urandom));
      set_reg(REG_NUM_ROWS, rows_raw);
      set_reg(REG_NUM_COLS, cols_raw);

      rows_used = grid_extent(rows_cfg, MaxRowsDef);
      cols_used = grid_extent(cols_cfg, MaxColsDef);
      patch_r = (rows_used < PatchMax) ? rows_used : PatchMax;
      patch_c = (cols_used < PatchMax) ? cols_used : PatchMax;
      density = $urandom_range(40, 75);

      for (r = 0; r < patch_r; r++) begin
        for (c = 0; c < patch_c; c++) begin
          issue(make_item(CMD_WRITE, r, c, $urandom_range(0, 99) < density), WANT_MODEL);
        end
      end
      issue(make_item(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                      1'($urandom)), WANT_MODEL);
      for (r = 0; r < patch_r; r++) begin
        for (c = 0; c < patch_c; c++) begin
          issue(make_item(CMD_READ, r, c, 1'($urandom)), WANT_MODEL);
        end
      end

      // Noise: any command, any coordinate, in or out of range.
      repeat ($urandom_range(6, 14)) begin
        issue(make_item(2'($urandom_range(0, 3)), $urandom_range(0, 63),
                        $urandom_range(0, 63), 1'($urandom)), WANT_MODEL);
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    steady = 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk_i);
    // Idle on to catch any stray result.
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== border_connected_region_fill_unit.f =====
src/bcrf_pkg.sv
src/border_connected_region_fill_unit.sv
tb/sv/tb_top.sv
